[hdl/pwlc_pkg.sv]
`timescale 1ns / 1ps

package pwlc_pkg;

    localparam int PWLC_NUM_POINTS = 3;
    localparam int PWLC_FRAC_BITS  = 15;

    // fixed widths of the request and result fields
    localparam int XW   = 17;
    localparam int IDXW = 4;
    localparam int OW   = 16;

    typedef enum logic [1:0] {
        ADDR_SCAN,
        ADDR_K_LO,
        ADDR_K_HI
    } addr_sel_t;

    typedef enum logic [1:0] {
        RES_READ_Y,
        RES_PREV_Y,
        RES_INTERP,
        RES_MOVE
    } res_sel_t;

    typedef struct packed {
        logic      load;
        logic      take_prev;
        logic      seg_setup;
        logic      mul;
        logic      div_step;
        logic      clamp_lo;
        logic      clamp_hi;
        logic      write_pt;
        logic      capture;
        logic      out_load;
        addr_sel_t addr_sel;
        res_sel_t  res_sel;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic bad;
        logic below;
        logic x_le;
        logic dx_zero;
    } status_t;

endpackage

[hdl/piecewise_linear_curve_core.sv]
`timescale 1ns / 1ps
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// request  | in_valid / in_ready   | mode, x_in, point_index, new_x, new_y
// result   | out_valid / out_ready | curve_value, index_bad
//
// one request in work, one result each
// evaluate: below the first point, the y of the first point; beyond the last, the y of
//   the last; on a zero-width segment, the y at its start; else the point scan and
//   the restoring divider give the interpolated value
// move: neighbours read one at a time; an index out of range writes nothing and sets index_bad
// reset loads the evenly spaced descending line; a waiting result lets the next
//   request in, and that request stalls only when its own result is ready to leave

module piecewise_linear_curve_core
    import pwlc_pkg::*;
#(
    parameter int NUM_POINTS = PWLC_NUM_POINTS,
    parameter int FRAC_BITS  = PWLC_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic signed [XW-1:0] x_in,
    input  logic [IDXW-1:0]      point_index,
    input  logic signed [XW-1:0] new_x,
    input  logic signed [XW-1:0] new_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OW-1:0]        curve_value,
    output logic                 index_bad
);

    cmd_t                          cmd;
    status_t                       status;
    logic [$clog2(NUM_POINTS)-1:0] scan_idx;

    pwlc_ctrl #(
        .NUM_POINTS (NUM_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .scan_idx  (scan_idx)
    );

    pwlc_dp #(
        .NUM_POINTS (NUM_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .scan_idx    (scan_idx),
        .status      (status),
        .mode        (mode),
        .x_in        (x_in),
        .point_index (point_index),
        .new_x       (new_x),
        .new_y       (new_y),
        .curve_value (curve_value),
        .index_bad   (index_bad)
    );

endmodule

[hdl/pwlc_ctrl.sv]
`timescale 1ns / 1ps

module pwlc_ctrl
    import pwlc_pkg::*;
#(
    parameter int NUM_POINTS = PWLC_NUM_POINTS,
    parameter int FRAC_BITS  = PWLC_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  status_t                       status,
    output cmd_t                          cmd,
    output logic [$clog2(NUM_POINTS)-1:0] scan_idx
);

    localparam int IW   = $clog2(NUM_POINTS);
    localparam int PW   = FRAC_BITS + 1;
    localparam int CNTW = $clog2(PW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_CHECK,
        S_DIV,
        S_FIN,
        S_MV_HI,
        S_MV_WR,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.addr_sel   = ADDR_SCAN;
        cmd.res_sel    = RES_READ_Y;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    scan_idx_next = '0;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (!status.mode)
                begin
                    cmd.take_prev = 1'b1;
                    if (status.below)
                    begin
                        // query left of the first point
                        cmd.capture = 1'b1;
                        cmd.res_sel = RES_READ_Y;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        scan_idx_next = IW'(1);
                        state_next    = S_SCAN;
                    end
                end
                else if (status.bad)
                begin
                    cmd.capture = 1'b1;
                    cmd.res_sel = RES_MOVE;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.addr_sel = ADDR_K_LO;
                    cmd.clamp_lo = 1'b1;
                    state_next   = S_MV_HI;
                end
            end
            S_SCAN:
            begin
                if (status.x_le)
                begin
                    cmd.seg_setup = 1'b1;
                    state_next    = S_CHECK;
                end
                else if (scan_idx_reg == IW'(NUM_POINTS - 1))
                begin
                    // query right of the last point
                    cmd.capture = 1'b1;
                    cmd.res_sel = RES_READ_Y;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.take_prev = 1'b1;
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end
            S_CHECK:
            begin
                if (status.dx_zero)
                begin
                    cmd.capture = 1'b1;
                    cmd.res_sel = RES_PREV_Y;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(PW - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.capture = 1'b1;
                cmd.res_sel = RES_INTERP;
                state_next  = S_OUT;
            end
            S_MV_HI:
            begin
                cmd.addr_sel = ADDR_K_HI;
                cmd.clamp_hi = 1'b1;
                state_next   = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.write_pt = 1'b1;
                cmd.capture  = 1'b1;
                cmd.res_sel  = RES_MOVE;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scan_idx  = scan_idx_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= CNTW'(PW - 1))
        else $error("division step count overran");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load did not raise out_valid");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_START && !in_ready)
        else $error("request accepted outside idle");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg != '0)
        else $error("segment scan at first point");

endmodule

[hdl/pwlc_dp.sv]
`timescale 1ns / 1ps

module pwlc_dp
    import pwlc_pkg::*;
#(
    parameter int NUM_POINTS = PWLC_NUM_POINTS,
    parameter int FRAC_BITS  = PWLC_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic [$clog2(NUM_POINTS)-1:0] scan_idx,
    output status_t                       status,
    input  logic                          mode,
    input  logic signed [XW-1:0]          x_in,
    input  logic [IDXW-1:0]               point_index,
    input  logic signed [XW-1:0]          new_x,
    input  logic signed [XW-1:0]          new_y,
    output logic [OW-1:0]                 curve_value,
    output logic                          index_bad
);

    localparam int IW = $clog2(NUM_POINTS);
    localparam int PW = FRAC_BITS + 1;
    localparam int CW = ((PW > XW) ? PW : XW) + 1;
    localparam longint NUM_SEG = NUM_POINTS - 1;
    localparam longint ONE_L   = 64'sd1 << FRAC_BITS;
    localparam logic [PW-1:0]        ONE_U = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [CW-1:0] ONE_S = $signed({{(CW - PW){1'b0}}, ONE_U});

    logic [PW-1:0] x_tab_reg [NUM_POINTS];
    logic [PW-1:0] y_tab_reg [NUM_POINTS];

    logic                 mode_reg;
    logic                 bad_reg;
    logic signed [XW-1:0] x_reg;
    logic [IW-1:0]        k_reg;
    logic [PW-1:0]        nx_reg;
    logic [PW-1:0]        ny_reg;
    logic [PW-1:0]        prev_x_reg;
    logic [PW-1:0]        prev_y_reg;
    logic [PW-1:0]        dx_reg;
    logic [PW-1:0]        t_reg;
    logic [PW-1:0]        dy_mag_reg;
    logic                 dy_neg_reg;
    logic [PW-1:0]        rem_reg;
    logic [PW-1:0]        quo_reg;
    logic [PW-1:0]        res_val_reg;
    logic                 res_bad_reg;
    logic [OW-1:0]        curve_value_reg;
    logic                 index_bad_reg;

    logic [IW-1:0]        addr_raw;
    logic [IW-1:0]        rd_idx;
    logic [PW-1:0]        rd_x;
    logic [PW-1:0]        rd_y;
    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] rdx_ext;
    logic signed [CW-1:0] prevx_ext;
    logic signed [CW-1:0] t_diff;
    logic signed [PW:0]   dy_s;
    logic [PW:0]          dy_abs;
    logic signed [CW-1:0] nx_ext;
    logic signed [CW-1:0] ny_ext;
    logic [PW-1:0]        nx_clamp;
    logic [PW-1:0]        ny_clamp;
    logic                 k_first;
    logic                 k_last;
    logic [2*PW-1:0]      prod;
    logic [PW:0]          div_shift;
    logic [PW:0]          div_diff;
    logic                 div_ge;
    logic [PW:0]          q_ext;
    logic [PW:0]          interp_sum;
    logic [PW-1:0]        res_val;
    logic [PW+OW-1:0]     out_wide;

    // one read port into the point tables
    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_SCAN: addr_raw = scan_idx;
            ADDR_K_LO: addr_raw = k_reg - IW'(1);
            ADDR_K_HI: addr_raw = k_reg + IW'(1);
            default:   addr_raw = scan_idx;
        endcase
    end

    assign rd_idx = ({1'b0, addr_raw} < (IW + 1)'(NUM_POINTS)) ? addr_raw : '0;
    assign rd_x   = x_tab_reg[rd_idx];
    assign rd_y   = y_tab_reg[rd_idx];

    assign x_ext     = CW'(x_reg);
    assign rdx_ext   = $signed({{(CW - PW){1'b0}}, rd_x});
    assign prevx_ext = $signed({{(CW - PW){1'b0}}, prev_x_reg});
    assign t_diff    = x_ext - prevx_ext;
    assign dy_s      = $signed({1'b0, rd_y}) - $signed({1'b0, prev_y_reg});
    assign dy_abs    = dy_s[PW] ? (~dy_s + 1'b1) : dy_s;

    // saturate a move request into the unit range
    assign nx_ext = CW'(new_x);
    assign ny_ext = CW'(new_y);

    always_comb
    begin
        priority if (nx_ext < 0)
            nx_clamp = '0;
        else if (nx_ext > ONE_S)
            nx_clamp = ONE_U;
        else
            nx_clamp = nx_ext[PW-1:0];

        priority if (ny_ext < 0)
            ny_clamp = '0;
        else if (ny_ext > ONE_S)
            ny_clamp = ONE_U;
        else
            ny_clamp = ny_ext[PW-1:0];
    end

    assign k_first = (k_reg == '0);
    assign k_last  = (k_reg == IW'(NUM_POINTS - 1));

    assign prod = (2 * PW)'(t_reg) * (2 * PW)'(dy_mag_reg);

    // restoring division, one quotient bit per step
    assign div_shift = {rem_reg, quo_reg[PW-1]};
    assign div_diff  = div_shift - {1'b0, dx_reg};
    assign div_ge    = (div_shift >= {1'b0, dx_reg});

    assign q_ext      = {1'b0, quo_reg};
    assign interp_sum = {1'b0, prev_y_reg} + (dy_neg_reg ? (~q_ext + 1'b1) : q_ext);

    always_comb
    begin
        unique case (cmd.res_sel)
            RES_READ_Y: res_val = rd_y;
            RES_PREV_Y: res_val = prev_y_reg;
            RES_INTERP: res_val = interp_sum[PW-1:0];
            RES_MOVE:   res_val = '0;
            default:    res_val = '0;
        endcase
    end

    assign out_wide = {{OW{1'b0}}, res_val_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                x_tab_reg[i] <= PW'((longint'(i) * ONE_L) / NUM_SEG);
                y_tab_reg[i] <= PW'(ONE_L - (longint'(i) * ONE_L) / NUM_SEG);
            end
        end
        else if (cmd.write_pt)
        begin
            x_tab_reg[k_reg] <= nx_reg;
            y_tab_reg[k_reg] <= ny_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            x_reg    <= x_in;
            bad_reg  <= ({1'b0, point_index} >= (IDXW + 1)'(NUM_POINTS));
            k_reg    <= point_index[IW-1:0];
            nx_reg   <= nx_clamp;
            ny_reg   <= ny_clamp;
        end
        if (cmd.clamp_lo && !k_first && nx_reg < rd_x)
        begin
            nx_reg <= rd_x;
        end
        if (cmd.clamp_hi && !k_last && nx_reg > rd_x)
        begin
            nx_reg <= rd_x;
        end
        if (cmd.take_prev)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (cmd.seg_setup)
        begin
            dx_reg     <= rd_x - prev_x_reg;
            t_reg      <= t_diff[PW-1:0];
            dy_neg_reg <= dy_s[PW];
            dy_mag_reg <= dy_abs[PW-1:0];
        end
        if (cmd.mul)
        begin
            rem_reg <= prod[2*PW-1:PW];
            quo_reg <= prod[PW-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[PW-1:0] : div_shift[PW-1:0];
            quo_reg <= {quo_reg[PW-2:0], div_ge};
        end
        if (cmd.capture)
        begin
            res_val_reg <= res_val;
            res_bad_reg <= (cmd.res_sel == RES_MOVE) && bad_reg;
        end
        if (cmd.out_load)
        begin
            curve_value_reg <= out_wide[OW-1:0];
            index_bad_reg   <= res_bad_reg;
        end
    end

    assign status.mode    = mode_reg;
    assign status.bad     = bad_reg;
    assign status.below   = (x_ext < rdx_ext);
    assign status.x_le    = (x_ext <= rdx_ext);
    assign status.dx_zero = (dx_reg == '0);

    assign curve_value = curve_value_reg;
    assign index_bad   = index_bad_reg;

    for (genvar g = 0; g < NUM_POINTS - 1; g++)
    begin : g_order
        a_x_ascending: assert property (@(posedge clk) disable iff (!rst_n)
            x_tab_reg[g] <= x_tab_reg[g + 1])
            else $error("control point x out of order");
    end

endmodule
